>>> src/gcoe_pkg.sv
// Shared constants, codes and types of the GPS clock offset estimator.
`default_nettype none

package gcoe_pkg;

  // Sample batch and trimming
  localparam int SAMPLE_COUNT   = 10;
  localparam int TRIM_EACH_SIDE = 2;
  localparam int TRIM_USED      = (2 * TRIM_EACH_SIDE >= SAMPLE_COUNT) ?
                                  (SAMPLE_COUNT - 1) / 2 : TRIM_EACH_SIDE;
  localparam int KEEP_USED      = SAMPLE_COUNT - 2 * TRIM_USED;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ACT_W   = 2;
  localparam int TIME_W  = 63;
  localparam int OFS_W   = 64;
  localparam int GUARD_W = 20;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 4;

  // Counters and arithmetic widths
  localparam int IDX_W      = $clog2(SAMPLE_COUNT);
  localparam int CNT_W      = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W      = OFS_W + $clog2(SAMPLE_COUNT) + 1;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_BITS * DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int REM_W      = $clog2(KEEP_USED + 1);
  localparam logic [REM_W:0] KEEP_C = (REM_W + 1)'(KEEP_USED);

  // Register reset values
  localparam logic [GUARD_W-1:0] GUARD_RST   = GUARD_W'(30 * 60);
  localparam logic [CFG_W-1:0]   HOLD_RST    = CFG_W'(60 * 1000);
  localparam logic [CFG_W-1:0]   MIN_INT_RST = CFG_W'(60 * 1000);
  localparam logic [CFG_W-1:0]   STEP_RST    = CFG_W'(1000 * 1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_PRIMARY  = 2'd0,
    CMD_FALLBACK = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 2'd0,
    ACT_SLEW    = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_TIMEOUT = 2'd3
  } action_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_GUARD    = 2'd0,
    REG_HOLD     = 2'd1,
    REG_MIN_INT  = 2'd2,
    REG_STEP_THR = 2'd3
  } reg_idx_t;

  // One value moving between neighbouring sorter cells
  typedef struct packed {
    logic                    full;
    logic signed [OFS_W-1:0] data;
  } cell_link_t;

endpackage

`default_nettype wire

>>> src/gcoe_in_if.sv
// Input item channel of the GPS clock offset estimator.
`default_nettype none

interface gcoe_in_if;
  import gcoe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] local_time_ms;
  logic [TIME_W-1:0] gps_time_ms;

  modport source (output valid, output command, output local_time_ms, output gps_time_ms,
                  input ready);
  modport sink   (input valid, input command, input local_time_ms, input gps_time_ms,
                  output ready);
endinterface

`default_nettype wire

>>> src/gcoe_out_if.sv
// Result item channel of the GPS clock offset estimator.
`default_nettype none

interface gcoe_out_if;
  import gcoe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [OFS_W-1:0] offset_ms;
  logic [TIME_W-1:0]       set_time_ms;

  modport source (output valid, output action, output offset_ms, output set_time_ms,
                  input ready);
  modport sink   (input valid, input action, input offset_ms, input set_time_ms,
                  output ready);
endinterface

`default_nettype wire

>>> src/gps_clock_offset_estimator_unit.sv
// An ordinary item passes through evaluation and emit to the output register; the item that
// completes a batch of samples also goes through sorter drain, unload and divide.
// One item is taken at a time: the input is not ready again until the result has been handed
// to the output register, and a stalled output holds the result in the emit state.
// Reset: synchronous, active low; registers return to their defaults, the guard is armed
// and the sorter cells are empty. No clearing pass is needed.
`default_nettype none

module gps_clock_offset_estimator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  gcoe_in_if.sink                     in_ch,
  gcoe_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcoe_pkg::ADDR_W-1:0] paddr,
  input  logic [gcoe_pkg::CFG_W-1:0]  pwdata,
  output logic [gcoe_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);
  import gcoe_pkg::*;

  // One-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,  // wait for an item
    ST_EVAL  = 7'b0000010,  // gates, guard and sample capture
    ST_DRAIN = 7'b0000100,  // let the last insertion settle in the chain
    ST_SUM   = 7'b0001000,  // unload the sorted chain, sum the kept middle
    ST_DIVGO = 7'b0010000,  // launch the divider
    ST_DIV   = 7'b0100000,  // wait for the mean
    ST_EMIT  = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // Held item
  cmd_t              cmd_r, cmd_nxt;
  logic [TIME_W-1:0] local_r, local_nxt;
  logic [TIME_W-1:0] gps_r, gps_nxt;

  // Configuration registers
  logic [GUARD_W-1:0] guard_sec_r, guard_sec_nxt;
  logic [CFG_W-1:0]   hold_r, hold_nxt;
  logic [CFG_W-1:0]   min_int_r, min_int_nxt;
  logic [CFG_W-1:0]   step_thr_r, step_thr_nxt;

  // Discipline state
  logic [GUARD_W-1:0] guard_rem_r, guard_rem_nxt;
  logic               guard_armed_r, guard_armed_nxt;
  logic [TIME_W-1:0]  last_primary_r, last_primary_nxt;
  logic [OFS_W-1:0]   last_adjust_r, last_adjust_nxt;
  logic [IDX_W-1:0]   sample_cnt_r, sample_cnt_nxt;

  // Sorter feed and unload
  logic                    ins_full_r, ins_full_nxt;
  logic signed [OFS_W-1:0] ins_data_r, ins_data_nxt;
  logic [CNT_W-1:0]        shift_cnt_r, shift_cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Pending result and output register
  action_t                 res_action_r, res_action_nxt;
  logic signed [OFS_W-1:0] res_offset_r, res_offset_nxt;
  logic [TIME_W-1:0]       res_set_r, res_set_nxt;
  logic                    out_valid_r, out_valid_nxt;
  action_t                 out_action_r, out_action_nxt;
  logic signed [OFS_W-1:0] out_offset_r, out_offset_nxt;
  logic [TIME_W-1:0]       out_set_r, out_set_nxt;

  // Datapath nets
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;
  logic [GUARD_W-1:0]      guard_dec;
  logic [OFS_W-1:0]        hold_edge;
  logic                    hold_drop;
  logic [OFS_W-1:0]        gap;
  logic                    gap_drop;
  logic signed [OFS_W-1:0] sample;
  logic [IDX_W-1:0]        cnt_inc;
  logic                    in_kept;
  logic signed [SUM_W-1:0] head_ext;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_start;
  logic                    div_done;
  logic [OFS_W-1:0]        div_quot;
  logic [OFS_W-1:0]        mean_mag;
  logic signed [OFS_W-1:0] mean;
  logic                    chain_busy;
  logic                    cell_shift;

  // Sorter chain: link i feeds cell i from the left, val i is cell i's held value
  cell_link_t ins_link [SAMPLE_COUNT+1];
  cell_link_t val_link [SAMPLE_COUNT+1];

  assign ins_link[0]            = '{full: ins_full_r, data: ins_data_r};
  assign val_link[SAMPLE_COUNT] = '{full: 1'b0, data: '0};
  assign cell_shift             = (state_r == ST_SUM);

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    gcoe_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (cell_shift),
      .ins_i  (ins_link[i]),
      .shl_i  (val_link[i+1]),
      .pass_o (ins_link[i+1]),
      .val_o  (val_link[i])
    );
  end

  // Any insertion still rippling through the chain
  always_comb begin
    chain_busy = 1'b0;
    for (int j = 1; j <= SAMPLE_COUNT; j++) begin
      chain_busy = chain_busy | ins_link[j].full;
    end
  end

  // Mean of the kept samples: divide the magnitude, restore the sign
  assign sum_neg   = sum_r[SUM_W-1];
  assign sum_mag   = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start = (state_r == ST_DIVGO);

  gcoe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign mean_mag = {1'b0, div_quot[TIME_W-1:0]};
  assign mean     = sum_neg ? -$signed(mean_mag) : $signed(mean_mag);

  // Gates and sample arithmetic on the held item
  assign guard_dec = (guard_rem_r != '0) ? guard_rem_r - 1'b1 : '0;
  // exact sum: 63-bit time plus 32-bit window never wraps in 64 bits
  assign hold_edge = {1'b0, last_primary_r} + {{(OFS_W-CFG_W){1'b0}}, hold_r};
  assign hold_drop = (cmd_r == CMD_FALLBACK) && (hold_edge > {1'b0, gps_r});
  // unsigned gap, so an earlier GPS time wraps round and passes
  assign gap       = {1'b0, gps_r} - last_adjust_r;
  assign gap_drop  = gap < {{(OFS_W-CFG_W){1'b0}}, min_int_r};
  assign sample    = $signed({1'b0, gps_r} - {1'b0, local_r});
  assign cnt_inc   = (sample_cnt_r == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : sample_cnt_r + 1'b1;

  // Unload: the head shows the sorted values lowest first
  assign in_kept  = (shift_cnt_r >= CNT_W'(TRIM_USED)) &&
                    (shift_cnt_r < CNT_W'(SAMPLE_COUNT - TRIM_USED));
  assign head_ext = {{(SUM_W-OFS_W){val_link[0].data[OFS_W-1]}}, val_link[0].data};

  // Configuration port
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_GUARD:    prdata = CFG_W'(guard_sec_r);
      REG_HOLD:     prdata = hold_r;
      REG_MIN_INT:  prdata = min_int_r;
      REG_STEP_THR: prdata = step_thr_r;
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    local_nxt        = local_r;
    gps_nxt          = gps_r;
    guard_sec_nxt    = guard_sec_r;
    hold_nxt         = hold_r;
    min_int_nxt      = min_int_r;
    step_thr_nxt     = step_thr_r;
    guard_rem_nxt    = guard_rem_r;
    guard_armed_nxt  = guard_armed_r;
    last_primary_nxt = last_primary_r;
    last_adjust_nxt  = last_adjust_r;
    sample_cnt_nxt   = sample_cnt_r;
    ins_full_nxt     = 1'b0;
    ins_data_nxt     = ins_data_r;
    shift_cnt_nxt    = shift_cnt_r;
    sum_nxt          = sum_r;
    res_action_nxt   = res_action_r;
    res_offset_nxt   = res_offset_r;
    res_set_nxt      = res_set_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_action_nxt   = out_action_r;
    out_offset_nxt   = out_offset_r;
    out_set_nxt      = out_set_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.command);
          local_nxt = in_ch.local_time_ms;
          gps_nxt   = in_ch.gps_time_ms;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        res_action_nxt = ACT_NONE;
        res_offset_nxt = '0;
        res_set_nxt    = '0;
        state_nxt      = ST_EMIT;
        case (cmd_r) inside
          CMD_TICK: begin
            // count the guard down; report once on reaching zero
            if (guard_armed_r) begin
              guard_rem_nxt = guard_dec;
              if (guard_dec == '0) begin
                guard_armed_nxt = 1'b0;
                res_action_nxt  = ACT_TIMEOUT;
              end
            end
          end
          CMD_NOP: begin
          end
          CMD_PRIMARY, CMD_FALLBACK: begin
            // a primary stamp is remembered even when invalid
            if (cmd_r == CMD_PRIMARY) begin
              last_primary_nxt = gps_r;
            end
            if (gps_r != '0) begin
              guard_rem_nxt   = guard_sec_r;
              guard_armed_nxt = (guard_sec_r != '0);
              if (!hold_drop && !gap_drop) begin
                sample_cnt_nxt = cnt_inc;
                ins_full_nxt   = 1'b1;
                ins_data_nxt   = sample;
                // batch complete: take the mean before reporting
                if (cnt_inc == '0) begin
                  last_adjust_nxt = {1'b0, gps_r};
                  state_nxt       = ST_DRAIN;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_DRAIN: begin
        if (!ins_full_r && !chain_busy) begin
          sum_nxt       = '0;
          shift_cnt_nxt = '0;
          state_nxt     = ST_SUM;
        end
      end

      ST_SUM: begin
        if (in_kept) begin
          sum_nxt = sum_r + head_ext;
        end
        shift_cnt_nxt = shift_cnt_r + 1'b1;
        if (shift_cnt_r == CNT_W'(SAMPLE_COUNT - 1)) begin
          state_nxt = ST_DIVGO;
        end
      end

      ST_DIVGO: begin
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          // slew inside the threshold, otherwise step to the batch's last GPS time
          if (mean_mag < {{(OFS_W-CFG_W){1'b0}}, step_thr_r}) begin
            res_action_nxt = ACT_SLEW;
            res_offset_nxt = mean;
          end else begin
            res_action_nxt = ACT_STEP;
            res_set_nxt    = gps_r;
          end
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = res_action_r;
          out_offset_nxt = res_offset_r;
          out_set_nxt    = res_set_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes must arrive only while the block is idle; the block itself does not enforce this
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GUARD: begin
          guard_sec_nxt   = pwdata[GUARD_W-1:0];
          guard_rem_nxt   = pwdata[GUARD_W-1:0];
          guard_armed_nxt = (pwdata[GUARD_W-1:0] != '0);
        end
        REG_HOLD:     hold_nxt     = pwdata;
        REG_MIN_INT:  min_int_nxt  = pwdata;
        REG_STEP_THR: step_thr_nxt = pwdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      guard_sec_r    <= GUARD_RST;
      hold_r         <= HOLD_RST;
      min_int_r      <= MIN_INT_RST;
      step_thr_r     <= STEP_RST;
      guard_rem_r    <= GUARD_RST;
      guard_armed_r  <= (GUARD_RST != '0);
      last_primary_r <= '0;
      last_adjust_r  <= '0;
      sample_cnt_r   <= '0;
      ins_full_r     <= 1'b0;
      shift_cnt_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      guard_sec_r    <= guard_sec_nxt;
      hold_r         <= hold_nxt;
      min_int_r      <= min_int_nxt;
      step_thr_r     <= step_thr_nxt;
      guard_rem_r    <= guard_rem_nxt;
      guard_armed_r  <= guard_armed_nxt;
      last_primary_r <= last_primary_nxt;
      last_adjust_r  <= last_adjust_nxt;
      sample_cnt_r   <= sample_cnt_nxt;
      ins_full_r     <= ins_full_nxt;
      shift_cnt_r    <= shift_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    local_r      <= local_nxt;
    gps_r        <= gps_nxt;
    ins_data_r   <= ins_data_nxt;
    sum_r        <= sum_nxt;
    res_action_r <= res_action_nxt;
    res_offset_r <= res_offset_nxt;
    res_set_r    <= res_set_nxt;
    out_action_r <= out_action_nxt;
    out_offset_r <= out_offset_nxt;
    out_set_r    <= out_set_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_action_r;
  assign out_ch.offset_ms   = out_offset_r;
  assign out_ch.set_time_ms = out_set_r;

endmodule

`default_nettype wire

>>> src/gcoe_cell.sv
// One cell of the systolic insertion sorter: keeps the smaller value, passes the larger on.
`default_nettype none

module gcoe_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  gcoe_pkg::cell_link_t ins_i,
  input  gcoe_pkg::cell_link_t shl_i,
  output gcoe_pkg::cell_link_t pass_o,
  output gcoe_pkg::cell_link_t val_o
);
  import gcoe_pkg::*;

  logic                    full_r, full_nxt;
  logic signed [OFS_W-1:0] val_r, val_nxt;
  logic                    pass_full_r, pass_full_nxt;
  logic signed [OFS_W-1:0] pass_data_r, pass_data_nxt;

  always_comb begin
    full_nxt      = full_r;
    val_nxt       = val_r;
    pass_full_nxt = 1'b0;
    pass_data_nxt = pass_data_r;
    if (shift) begin
      // unload towards the head
      full_nxt = shl_i.full;
      val_nxt  = shl_i.data;
    end else if (ins_i.full) begin
      if (!full_r) begin
        full_nxt = 1'b1;
        val_nxt  = ins_i.data;
      end else if ($signed(ins_i.data) < $signed(val_r)) begin
        val_nxt       = ins_i.data;
        pass_full_nxt = 1'b1;
        pass_data_nxt = val_r;
      end else begin
        pass_full_nxt = 1'b1;
        pass_data_nxt = ins_i.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= 1'b0;
      pass_full_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      pass_full_r <= pass_full_nxt;
    end
    val_r       <= val_nxt;
    pass_data_r <= pass_data_nxt;
  end

  assign pass_o = '{full: pass_full_r, data: pass_data_r};
  assign val_o  = '{full: full_r, data: val_r};

endmodule

`default_nettype wire

>>> src/gcoe_div.sv
// Divider by the kept-sample count, four quotient bits a cycle.
`default_nettype none

module gcoe_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gcoe_pkg::SUM_W-1:0]   dividend,
  output logic                         done,
  output logic [gcoe_pkg::OFS_W-1:0]   quotient
);
  import gcoe_pkg::*;

  logic [DIV_W-1:0]     dq_r, dq_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    logic [REM_W:0]   cur;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dq;
    rem      = rem_r;
    dq       = dq_r;
    cur      = '0;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem      = '0;
      dq       = DIV_W'(dividend);
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      // restoring steps: shift in the next dividend bit, shift out a quotient bit
      for (int j = 0; j < DIV_BITS; j++) begin
        cur = {rem, dq[DIV_W-1]};
        dq  = {dq[DIV_W-2:0], 1'b0};
        if (cur >= KEEP_C) begin
          rem   = REM_W'(cur - KEEP_C);
          dq[0] = 1'b1;
        end else begin
          rem = cur[REM_W-1:0];
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    rem_nxt = rem;
    dq_nxt  = dq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r[OFS_W-1:0];

endmodule

`default_nettype wire

>>> src/gcoe_checker.sv
// Port-level checks of the GPS clock offset estimator, bound to the top level.
`default_nettype none

module gcoe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gcoe_pkg::ACT_W-1:0]        out_action,
  input logic signed [gcoe_pkg::OFS_W-1:0] out_offset_ms,
  input logic [gcoe_pkg::TIME_W-1:0]       out_set_time_ms
);
  import gcoe_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_offset_ms) && $stable(out_set_time_ms))
    else $error("result changed while stalled");

  // one item at a time: busy straight after an acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again right after acceptance");

  a_slew: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_SLEW) |-> out_set_time_ms == '0)
    else $error("slew result carries a set time");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_STEP) |-> (out_offset_ms == '0) &&
      (out_set_time_ms != '0))
    else $error("step result malformed");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_action == ACT_NONE) || (out_action == ACT_TIMEOUT)) |->
      (out_offset_ms == '0) && (out_set_time_ms == '0))
    else $error("plain result carries a payload");

endmodule

bind gps_clock_offset_estimator_unit gcoe_checker u_gcoe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_action      (out_ch.action),
  .out_offset_ms   (out_ch.offset_ms),
  .out_set_time_ms (out_ch.set_time_ms)
);

`default_nettype wire
